FILE: hw/rtl/rpbc_pkg.sv
// Shared types and constants for the RGB565 pixel blend/clip block.
// Request and response words, register indexes, default store depth.
// No dependencies.
`timescale 1ns / 1ps

package rpbc_pkg;

   // default frame store depth in pixels
   localparam int FB_PIXELS_DEF = 262144;

   // fixed field widths
   localparam int COORD_W = 12;
   localparam int COLOR_W = 16;
   localparam int ALPHA_W = 8;
   localparam int ADDR_W  = 18;
   localparam int DIM_W   = 10;
   localparam int OFF_W   = 11;
   localparam int IDX_W   = 3;
   // y * width + x before the store bound check
   localparam int LIN_W   = 21;

   // configuration register indexes
   localparam logic [IDX_W-1:0] REG_CANVAS_WIDTH  = 3'd0;
   localparam logic [IDX_W-1:0] REG_CANVAS_HEIGHT = 3'd1;
   localparam logic [IDX_W-1:0] REG_CLIP_LEFT     = 3'd2;
   localparam logic [IDX_W-1:0] REG_CLIP_TOP      = 3'd3;
   localparam logic [IDX_W-1:0] REG_CLIP_RIGHT    = 3'd4;
   localparam logic [IDX_W-1:0] REG_CLIP_BOTTOM   = 3'd5;
   localparam logic [IDX_W-1:0] REG_OFFSET_X      = 3'd6;
   localparam logic [IDX_W-1:0] REG_OFFSET_Y      = 3'd7;

   // mode codes
   localparam logic MODE_SET   = 1'b0;
   localparam logic MODE_BLEND = 1'b1;

   typedef struct packed {
      logic                     mode;
      logic [COORD_W-1:0]       pos_x;
      logic [COORD_W-1:0]       pos_y;
      logic [COLOR_W-1:0]       src_color;
      logic [ALPHA_W-1:0]       alpha;
   } req_type;

   typedef struct packed {
      logic                     written;
      logic [ADDR_W-1:0]        pixel_address;
      logic [COLOR_W-1:0]       pixel_value;
   } rsp_type;

endpackage

FILE: hw/rtl/rpbc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth are parameters. No dependencies.
`timescale 1ns / 1ps

module rpbc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/rgb565_pixel_blend_clip.sv
// Top level of the RGB565 pixel blend/clip block: offset, bound and clip
// checks, address generation, read-modify-write blend into the frame store.
// Depends on rpbc_pkg and rpbc_ram.
`timescale 1ns / 1ps

//  channel   ports                         direction  handshake
//  request   start, busy, req_data         in         start && !busy
//  response  rsp_strobe, rsp_data          out        strobe, one cycle
//  config    csr_valid, csr_ready,         in         valid && ready
//            csr_index, csr_wdata
//
// One request at a time. A plain set, a blend with full alpha, or any dropped
// pixel holds busy through the check, address and output states after
// acceptance; other blends also pass the frame store read and channel mix
// states. The response word shows in the cycle busy falls, so a new request
// may be taken in that same cycle. After reset the frame store is cleared
// one entry per cycle over all FB_PIXELS entries, with busy high; config
// writes are taken throughout. The response side has no back-pressure.

module rgb565_pixel_blend_clip #(
   parameter int FB_PIXELS = rpbc_pkg::FB_PIXELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  rpbc_pkg::req_type                   req_data,
   output logic                                rsp_strobe,
   output rpbc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rpbc_pkg::IDX_W-1:0]          csr_index,
   input  logic [rpbc_pkg::OFF_W-1:0]          csr_wdata
);

   import rpbc_pkg::*;

   localparam int AW    = $clog2(FB_PIXELS);
   localparam int CLR_W = AW + 1;
   localparam logic [CLR_W-1:0] CLR_END = CLR_W'(FB_PIXELS);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_ADDR  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_MIX   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   // configuration registers
   logic [DIM_W-1:0] width_ff,  height_ff;
   logic [DIM_W-1:0] left_ff,   top_ff, right_ff, bottom_ff;
   logic [OFF_W-1:0] off_x_ff,  off_y_ff;

   // control
   logic [2:0]       state_ff,  state_in;
   logic [CLR_W-1:0] clear_ff;
   logic             clearing;
   logic             accept;
   logic             strobe_ff;

   // per-request datapath
   req_type          req_ff;
   logic             ok_ff,     ok_in;
   logic             blend_ff;
   logic [DIM_W-1:0] x_ff,      y_ff;
   logic [LIN_W-1:0] lin_ff,    lin_in;
   logic [15:0]      mix_r_ff,  mix_g_ff, mix_b_ff;
   rsp_type          rsp_ff;

   // combinational
   logic signed [COORD_W:0] x_sum, y_sum;
   logic             in_canvas, in_clip, clip_on;
   logic             in_store;
   logic [COLOR_W-1:0] dst_color, out_color, mixed;
   logic [7:0]       div_r, div_g, div_b;

   // memory port
   logic             wr_en, rd_en;
   logic [AW-1:0]    wr_addr;
   logic [COLOR_W-1:0] wr_data;

   // s*a + d*(255-a) on 8-bit channel values
   function automatic logic [15:0] mix_ch(input logic [7:0] s, input logic [7:0] d,
                                          input logic [7:0] a);
      logic [15:0] ps, pd;
      ps = 16'(s) * 16'(a);
      pd = 16'(d) * 16'(8'hFF - a);
      return ps + pd;
   endfunction

   // floor(v / 255) for v up to 255*255
   function automatic logic [7:0] div255(input logic [15:0] v);
      logic [16:0] t;
      t = 17'(v) + 17'd1 + 17'(v[15:8]);
      return t[15:8];
   endfunction

   assign clearing   = (clear_ff != CLR_END);
   assign busy       = clearing || (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign csr_ready  = 1'b1;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // ---------------------------------------------------------------------
   // Config writes: 10-bit registers take the low bits, offsets all 11.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
         left_ff   <= '0;
         top_ff    <= '0;
         right_ff  <= '0;
         bottom_ff <= '0;
         off_x_ff  <= '0;
         off_y_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_CANVAS_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            REG_CANVAS_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            REG_CLIP_LEFT:     left_ff   <= csr_wdata[DIM_W-1:0];
            REG_CLIP_TOP:      top_ff    <= csr_wdata[DIM_W-1:0];
            REG_CLIP_RIGHT:    right_ff  <= csr_wdata[DIM_W-1:0];
            REG_CLIP_BOTTOM:   bottom_ff <= csr_wdata[DIM_W-1:0];
            REG_OFFSET_X:      off_x_ff  <= csr_wdata;
            REG_OFFSET_Y:      off_y_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Position check: apply the offset, then the canvas and clip bounds.
   // Coordinates that pass are below the canvas size and fit 10 bits.
   // ---------------------------------------------------------------------
   always_comb begin
      x_sum = $signed({req_ff.pos_x[COORD_W-1], req_ff.pos_x})
            + $signed({{(COORD_W+1-OFF_W){off_x_ff[OFF_W-1]}}, off_x_ff});
      y_sum = $signed({req_ff.pos_y[COORD_W-1], req_ff.pos_y})
            + $signed({{(COORD_W+1-OFF_W){off_y_ff[OFF_W-1]}}, off_y_ff});

      in_canvas = !x_sum[COORD_W] && !y_sum[COORD_W]
               && (x_sum[COORD_W-1:0] < COORD_W'(width_ff))
               && (y_sum[COORD_W-1:0] < COORD_W'(height_ff));

      clip_on = (right_ff > left_ff);
      in_clip = (x_sum[COORD_W-1:0] >= COORD_W'(left_ff))
             && (x_sum[COORD_W-1:0] <  COORD_W'(right_ff))
             && (y_sum[COORD_W-1:0] >= COORD_W'(top_ff))
             && (y_sum[COORD_W-1:0] <  COORD_W'(bottom_ff));
   end

   // linear address and store bound
   assign lin_in   = LIN_W'(y_ff) * LIN_W'(width_ff) + LIN_W'(x_ff);
   assign in_store = (32'(lin_in) < 32'(FB_PIXELS));

   // ---------------------------------------------------------------------
   // Blend: widen each stored channel to 8 bits, mix, truncate back.
   // ---------------------------------------------------------------------
   assign div_r = div255(mix_r_ff);
   assign div_g = div255(mix_g_ff);
   assign div_b = div255(mix_b_ff);
   assign mixed = {div_r[7:3], div_g[7:2], div_b[7:3]};
   assign out_color = blend_ff ? mixed : req_ff.src_color;

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      ok_in    = ok_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // drop when off canvas, clipped, or a blend with zero alpha
            ok_in = in_canvas && (!clip_on || in_clip)
                 && !(req_ff.mode == MODE_BLEND && req_ff.alpha == '0);
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            ok_in = ok_ff && in_store;
            state_in = (ok_ff && in_store && blend_ff) ? ST_READ : ST_OUT;
         end
         ST_READ:  state_in = ST_MIX;
         ST_MIX:   state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         clear_ff  <= '0;
         strobe_ff <= 1'b0;
         ok_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ok_ff     <= ok_in;
         strobe_ff <= (state_ff == ST_OUT);
         if (clearing) begin
            clear_ff <= clear_ff + 1'b1;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff   <= req_data;
         blend_ff <= (req_data.mode == MODE_BLEND) && (req_data.alpha != 8'hFF);
      end
      if (state_ff == ST_CHECK) begin
         x_ff <= x_sum[DIM_W-1:0];
         y_ff <= y_sum[DIM_W-1:0];
      end
      if (state_ff == ST_ADDR) begin
         lin_ff <= lin_in;
      end
      if (state_ff == ST_MIX) begin
         mix_r_ff <= mix_ch({req_ff.src_color[15:11], 3'b000},
                            {dst_color[15:11], 3'b000}, req_ff.alpha);
         mix_g_ff <= mix_ch({req_ff.src_color[10:5], 2'b00},
                            {dst_color[10:5], 2'b00}, req_ff.alpha);
         mix_b_ff <= mix_ch({req_ff.src_color[4:0], 3'b000},
                            {dst_color[4:0], 3'b000}, req_ff.alpha);
      end
      if (state_ff == ST_OUT) begin
         if (ok_ff) begin
            rsp_ff.written       <= 1'b1;
            rsp_ff.pixel_address <= ADDR_W'(lin_ff);
            rsp_ff.pixel_value   <= out_color;
         end else begin
            rsp_ff <= '0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Frame store: clear sweep after reset, then one write per kept pixel.
   // Only one request is in flight, so a read never races its own write.
   // ---------------------------------------------------------------------
   always_comb begin
      if (clearing) begin
         wr_en   = 1'b1;
         wr_addr = clear_ff[AW-1:0];
         wr_data = '0;
      end else begin
         wr_en   = (state_ff == ST_OUT) && ok_ff;
         wr_addr = AW'(lin_ff);
         wr_data = out_color;
      end
   end

   assign rd_en = (state_ff == ST_READ);

   rpbc_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (FB_PIXELS)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (AW'(lin_ff)),
      .rd_data (dst_color)
   );

endmodule
